FILE: sv/xmbr_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM block receiver package
// Beat types, header bytes, status codes and the deframer phase encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package xmbr_pkg;

    // Input kinds.
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // Result kinds.
    localparam logic RES_DATA   = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    // Header bytes.
    localparam logic [7:0] HDR_SOH = 8'h01;
    localparam logic [7:0] HDR_STX = 8'h02;
    localparam logic [7:0] HDR_EOT = 8'h04;
    localparam logic [7:0] HDR_CAN = 8'h18;

    // Block lengths.
    localparam logic [10:0] LEN_LARGE = 11'd1024;
    localparam logic [10:0] LEN_SMALL = 11'd128;

    // Block status codes.
    localparam logic [1:0] ST_GOOD  = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Deframer phases.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SEQ    = 3'd1,
        PH_COMP   = 3'd2,
        PH_DATA   = 3'd3,
        PH_SUM    = 3'd4
    } phase_t;

    // One input beat.
    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [9:0]  byte_index;
        logic [1:0]  status;
        logic [10:0] block_length;
        logic [7:0]  sequence_res;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/xmbr_deframer.sv
// ----------------------------------------------------------------------------
// XMODEM deframer
// Holds the block state and turns each accepted beat into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module xmbr_deframer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step_en,
    input  wire xmbr_pkg::item_t  item,
    output logic                  step_valid,
    output xmbr_pkg::result_t     step_result
);

    xmbr_pkg::phase_t phase_reg, phase_next;
    logic             large_reg, large_next;
    logic [7:0]       seq_reg, seq_next;
    logic [10:0]      count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;

    logic             timeout;
    logic [7:0]       rx;
    logic [10:0]      blk_len;
    logic [10:0]      count_inc;
    logic [7:0]       got;
    logic             has_result;

    assign timeout   = (item.kind == xmbr_pkg::KIND_TIMEOUT);
    assign rx        = item.rx_byte;
    assign blk_len   = large_reg ? xmbr_pkg::LEN_LARGE : xmbr_pkg::LEN_SMALL;
    assign count_inc = count_reg + 11'd1;
    assign got       = timeout ? 8'h00 : rx;

    // State register; it only moves on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= xmbr_pkg::PH_HEADER;
            large_reg <= 1'b0;
            seq_reg   <= 8'h00;
            count_reg <= 11'd0;
            sum_reg   <= 8'h00;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            large_reg <= large_next;
            seq_reg   <= seq_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // Next state and the result of the current beat.
    always_comb
    begin
        phase_next  = phase_reg;
        large_next  = large_reg;
        seq_next    = seq_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        has_result  = 1'b0;
        step_result = '0;
        step_result.result_kind = xmbr_pkg::RES_STATUS;

        case (phase_reg)
            xmbr_pkg::PH_SEQ:
            begin
                if (timeout)
                begin
                    has_result         = 1'b1;
                    step_result.status = xmbr_pkg::ST_ERROR;
                    phase_next         = xmbr_pkg::PH_HEADER;
                end
                else
                begin
                    seq_next   = rx;
                    phase_next = xmbr_pkg::PH_COMP;
                end
            end
            xmbr_pkg::PH_COMP:
            begin
                if (timeout)
                begin
                    has_result         = 1'b1;
                    step_result.status = xmbr_pkg::ST_ERROR;
                    phase_next         = xmbr_pkg::PH_HEADER;
                end
                else if ((rx ^ seq_reg) != 8'hFF)
                begin
                    has_result               = 1'b1;
                    step_result.status       = xmbr_pkg::ST_ERROR;
                    step_result.sequence_res = seq_reg;
                    phase_next               = xmbr_pkg::PH_HEADER;
                end
                else
                begin
                    phase_next = xmbr_pkg::PH_DATA;
                end
            end
            xmbr_pkg::PH_DATA:
            begin
                if (timeout)
                begin
                    // A short block goes straight to the checksum.
                    phase_next = xmbr_pkg::PH_SUM;
                end
                else
                begin
                    has_result               = 1'b1;
                    step_result.result_kind  = xmbr_pkg::RES_DATA;
                    step_result.data_byte    = rx;
                    step_result.byte_index   = count_reg[9:0];
                    step_result.status       = xmbr_pkg::ST_GOOD;
                    step_result.sequence_res = seq_reg;
                    sum_next                 = sum_reg + rx;
                    count_next               = count_inc;
                    if (count_inc >= blk_len)
                    begin
                        phase_next = xmbr_pkg::PH_SUM;
                    end
                end
            end
            xmbr_pkg::PH_SUM:
            begin
                has_result               = 1'b1;
                step_result.sequence_res = seq_reg;
                phase_next               = xmbr_pkg::PH_HEADER;
                if (got != sum_reg)
                begin
                    step_result.status = xmbr_pkg::ST_ERROR;
                end
                else
                begin
                    step_result.status       = xmbr_pkg::ST_GOOD;
                    step_result.block_length = blk_len;
                end
            end
            default:
            begin
                // Waiting for a header byte.
                phase_next = xmbr_pkg::PH_HEADER;
                if (timeout)
                begin
                    has_result         = 1'b1;
                    step_result.status = xmbr_pkg::ST_ERROR;
                end
                else if (rx == xmbr_pkg::HDR_STX || rx == xmbr_pkg::HDR_SOH)
                begin
                    large_next = (rx == xmbr_pkg::HDR_STX);
                    count_next = 11'd0;
                    sum_next   = 8'h00;
                    seq_next   = 8'h00;
                    phase_next = xmbr_pkg::PH_SEQ;
                end
                else if (rx == xmbr_pkg::HDR_EOT || rx == xmbr_pkg::HDR_CAN)
                begin
                    has_result         = 1'b1;
                    step_result.status = xmbr_pkg::ST_END;
                end
                else
                begin
                    has_result         = 1'b1;
                    step_result.status = xmbr_pkg::ST_ERROR;
                end
            end
        endcase

        step_valid = step_en && has_result;
    end

endmodule

`default_nettype wire

FILE: sv/xmodem_block_receiver.sv
// Each result beat is registered, in the skid register first if the result port is stalled.
// Throughput: one input beat per cycle while item_stall is low.
// A two-entry output stage (result register plus skid register) holds one extra beat on a stall;
// item_stall rises only while both entries are full.
// Reset: phase returns to header wait, counters and sum clear, both output entries empty.
// ----------------------------------------------------------------------------
// XMODEM block receiver
// Deframes checksum-variant XMODEM blocks from a stream of bytes and timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_block_receiver (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire xmbr_pkg::item_t  item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output xmbr_pkg::result_t     result
);

    logic              fire;
    logic              step_valid;
    xmbr_pkg::result_t step_result;

    logic              out_valid_reg, out_valid_next;
    xmbr_pkg::result_t out_reg, out_next;
    logic              skid_valid_reg, skid_valid_next;
    xmbr_pkg::result_t skid_reg, skid_next;
    logic              out_free;

    assign item_stall = skid_valid_reg;
    assign fire       = item_valid && !item_stall;

    xmbr_deframer u_deframer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (fire),
        .item        (item),
        .step_valid  (step_valid),
        .step_result (step_result)
    );

    // Output stage steering: the result register takes the skid beat first.
    always_comb
    begin
        out_free        = !out_valid_reg || !result_stall;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = step_valid;
                out_next       = step_result;
            end
        end
        else if (step_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = step_result;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

FILE: sv/xmbr_checker.sv
// ----------------------------------------------------------------------------
// XMODEM block receiver checker
// Port-level properties of the receiver, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module xmbr_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_stall,
    input wire xmbr_pkg::item_t   item,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire xmbr_pkg::result_t result
);

    // Once reset is seen at a clock edge, nothing is offered on the result port next cycle.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result beat offered during reset");

    // A stalled result beat is held unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // Input stall only comes from a full output stage.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with empty result port");

    // Data beats carry no status and no block length.
    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == xmbr_pkg::RES_DATA
        |-> result.status == xmbr_pkg::ST_GOOD && result.block_length == 11'd0)
        else $error("data beat with status fields set");

    // Status beats: a good block reports a full length, anything else reports none.
    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == xmbr_pkg::RES_STATUS
        |-> result.data_byte == 8'h00 && result.byte_index == 10'd0
            && ((result.status == xmbr_pkg::ST_GOOD
                 && (result.block_length == xmbr_pkg::LEN_SMALL
                     || result.block_length == xmbr_pkg::LEN_LARGE))
                || ((result.status == xmbr_pkg::ST_END
                     || result.status == xmbr_pkg::ST_ERROR)
                    && result.block_length == 11'd0)))
        else $error("malformed status beat");

endmodule

bind xmodem_block_receiver xmbr_checker u_xmbr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
